// ===== rtl/mwpf_pkg.sv =====
// shared types, frame constants and crc helper for the mecanum wheel packet framer
// no dependencies

package mwpf_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int FRAME_LEN  = 10;

  localparam logic [8:0] RPM_CEILING   = 9'd330;
  localparam logic [7:0] CMD_BYTE      = 8'h64;
  localparam logic [7:0] ACCEL_BYTE    = 8'h0A;
  localparam logic [7:0] CRC_POLY      = 8'h8C;

  // byte positions inside one motor frame
  localparam logic [3:0] BYTE_ID     = 4'd0;
  localparam logic [3:0] BYTE_CMD    = 4'd1;
  localparam logic [3:0] BYTE_RPM_HI = 4'd2;
  localparam logic [3:0] BYTE_RPM_LO = 4'd3;
  localparam logic [3:0] BYTE_ACCEL  = 4'd6;
  localparam logic [3:0] BYTE_CRC    = 4'd9;

  // configuration register indexes
  localparam logic [1:0] REG_ARM     = 2'd0;
  localparam logic [1:0] REG_GAIN    = 2'd1;
  localparam logic [1:0] REG_LIMIT   = 2'd2;
  localparam logic [1:0] REG_REVERSE = 2'd3;

  // one command worth of wheel rpm values, motor 1 in element 0
  typedef logic [NUM_MOTORS-1:0][15:0] rpm_set_t;

  typedef struct packed {
    logic [17:0] arm_q16;
    logic [15:0] gain_q16;
    logic [8:0]  rpm_clamp;
    logic [3:0]  reverse_mask;
  } cfg_t;

  // reflected crc-8, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int j = 0; j < 8; j++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mecanum_wheel_packet_framer.sv =====
// mecanum wheel packet framer top level: config registers, front end, queue, back end
// depends on mwpf_pkg, mwpf_front, mwpf_queue, mwpf_back

// Each accepted velocity command (vel_x, vel_y in mm/s, yaw_rate in mrad/s) produces forty
// output beats: four 10-byte motor frames for motors 1..4, each ending in a reflected crc-8.
// A command passes the four front end stage registers, the queue, the back end entry register
// and the output register before its first beat appears. The byte serializer sends one byte per
// cycle while out_ready holds; the front end pipeline and a QUEUE_DEPTH-entry queue let up to
// QUEUE_DEPTH+4 further commands be taken while a command is still being sent.
// Configuration registers should only be written while no command is in flight.

module mecanum_wheel_packet_framer import mwpf_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_yaw_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic [2:0]         out_motor_number,
  output logic               out_last_of_frame,
  output logic               out_last_of_command
);

  cfg_t     cfg_r;
  logic     q_push, q_ready, q_valid, q_pop;
  rpm_set_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm_q16      <= 18'd49807;
      cfg_r.gain_q16     <= 16'd7823;
      cfg_r.rpm_clamp    <= 9'd30;
      cfg_r.reverse_mask <= 4'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARM:     cfg_r.arm_q16      <= cfg_wdata;
        REG_GAIN:    cfg_r.gain_q16     <= cfg_wdata[15:0];
        REG_LIMIT:   cfg_r.rpm_clamp    <= cfg_wdata[8:0];
        REG_REVERSE: cfg_r.reverse_mask <= cfg_wdata[3:0];
        default:     cfg_r              <= cfg_r;
      endcase
    end
  end

  mwpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .vel_x    (in_vel_x),
    .vel_y    (in_vel_y),
    .yaw_rate (in_yaw_rate),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_data   (q_wdata)
  );

  mwpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_wdata),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata)
  );

  mwpf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_data          (q_rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .tx_byte         (out_tx_byte),
    .motor_number    (out_motor_number),
    .last_of_frame   (out_last_of_frame),
    .last_of_command (out_last_of_command)
  );

endmodule

// ===== rtl/mwpf_front.sv =====
// front end: kinematics and rpm scaling pipeline, one command per cycle while the queue accepts
// depends on mwpf_pkg

module mwpf_front import mwpf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] yaw_rate,
  output logic               q_push,
  input  logic               q_ready,
  output rpm_set_t           q_data
);

  logic adv;

  logic               s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic signed [15:0] vx_r, vy_r;
  logic signed [34:0] rot_prod_r;
  logic signed [19:0] speed_r [NUM_MOTORS];
  logic signed [36:0] prod_r  [NUM_MOTORS];
  logic signed [20:0] trunc_r [NUM_MOTORS];

  logic signed [34:0] rot_prod_nxt;
  logic signed [19:0] rot_ext, vx_ext, vy_ext;
  logic signed [19:0] speed_nxt [NUM_MOTORS];
  logic signed [36:0] prod_nxt  [NUM_MOTORS];
  logic signed [36:0] biased    [NUM_MOTORS];
  logic signed [20:0] trunc_nxt [NUM_MOTORS];
  logic signed [10:0] lim, rpm_c [NUM_MOTORS];
  logic [8:0]         lim_u;

  // the whole pipe moves together; it holds only when the tail cannot enter the queue
  assign adv      = !s4_valid_r || q_ready;
  assign in_ready = adv;
  assign q_push   = s4_valid_r && q_ready;

  assign rot_prod_nxt = $signed({1'b0, cfg.arm_q16}) * yaw_rate;

  always_comb begin
    // arithmetic shift gives the floor
    rot_ext = 20'($signed(rot_prod_r[34:16]));
    vx_ext  = 20'(vx_r);
    vy_ext  = 20'(vy_r);
    speed_nxt[0] = vx_ext - vy_ext - rot_ext;
    speed_nxt[1] = vx_ext + vy_ext + rot_ext;
    speed_nxt[2] = vx_ext + vy_ext - rot_ext;
    speed_nxt[3] = vx_ext - vy_ext + rot_ext;
  end

  always_comb begin
    for (int m = 0; m < NUM_MOTORS; m++) begin
      prod_nxt[m] = speed_r[m] * $signed({1'b0, cfg.gain_q16});
      // bias negatives so the shift truncates toward zero
      biased[m]    = prod_r[m] + (prod_r[m][36] ? 37'sh0FFFF : 37'sh0);
      trunc_nxt[m] = biased[m][36:16];
    end
  end

  always_comb begin
    lim_u = (cfg.rpm_clamp > RPM_CEILING) ? RPM_CEILING : cfg.rpm_clamp;
    lim   = $signed({2'b00, lim_u});
    for (int m = 0; m < NUM_MOTORS; m++) begin
      if (trunc_r[m] > 21'(lim)) begin
        rpm_c[m] = lim;
      end else if (trunc_r[m] < -21'(lim)) begin
        rpm_c[m] = -lim;
      end else begin
        rpm_c[m] = trunc_r[m][10:0];
      end
      if (cfg.reverse_mask[m]) begin
        rpm_c[m] = -rpm_c[m];
      end
      q_data[m] = 16'(rpm_c[m]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r       <= vel_x;
      vy_r       <= vel_y;
      rot_prod_r <= rot_prod_nxt;
      for (int m = 0; m < NUM_MOTORS; m++) begin
        speed_r[m] <= speed_nxt[m];
        prod_r[m]  <= prod_nxt[m];
        trunc_r[m] <= trunc_nxt[m];
      end
    end
  end

endmodule

// ===== rtl/mwpf_queue.sv =====
// small fifo of rpm sets between the front end and the byte serializer
// depends on mwpf_pkg

module mwpf_queue import mwpf_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     push_ready,
  input  rpm_set_t push_data,
  input  logic     pop,
  output logic     pop_valid,
  output rpm_set_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  rpm_set_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mwpf_back.sv =====
// back end: walks four motor frames per rpm set, one byte per beat, running crc
// depends on mwpf_pkg

module mwpf_back import mwpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_pop,
  input  rpm_set_t   q_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic [2:0] motor_number,
  output logic       last_of_frame,
  output logic       last_of_command
);

  rpm_set_t   entry_r;
  logic       busy_r, busy_nxt;
  logic [1:0] motor_r, motor_nxt;
  logic [3:0] byte_r, byte_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] tx_byte_r;
  logic [2:0] motor_number_r;
  logic       last_frame_r, last_cmd_r;

  logic [15:0] rpm_cur;
  logic [7:0]  cur_byte;
  logic        is_last_frame, is_last_cmd, step, load;

  assign rpm_cur       = entry_r[motor_r];
  assign is_last_frame = (byte_r == BYTE_CRC);
  assign is_last_cmd   = is_last_frame && (motor_r == 2'(NUM_MOTORS - 1));
  assign step          = busy_r && (!out_valid_r || out_ready);
  // next set is taken while the last byte of the current one goes out
  assign load          = q_valid && (!busy_r || (step && is_last_cmd));
  assign q_pop         = load;

  always_comb begin
    case (byte_r)
      BYTE_ID:     cur_byte = {6'b0, motor_r} + 8'd1;
      BYTE_CMD:    cur_byte = CMD_BYTE;
      BYTE_RPM_HI: cur_byte = rpm_cur[15:8];
      BYTE_RPM_LO: cur_byte = rpm_cur[7:0];
      BYTE_ACCEL:  cur_byte = ACCEL_BYTE;
      BYTE_CRC:    cur_byte = crc_r;
      default:     cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    motor_nxt = motor_r;
    byte_nxt  = byte_r;
    crc_nxt   = crc_r;
    busy_nxt  = busy_r;
    if (load) begin
      motor_nxt = '0;
      byte_nxt  = BYTE_ID;
      crc_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (step) begin
      if (is_last_frame) begin
        motor_nxt = motor_r + 1'b1;
        byte_nxt  = BYTE_ID;
        crc_nxt   = '0;
        if (is_last_cmd) begin
          busy_nxt = 1'b0;
        end
      end else begin
        byte_nxt = byte_r + 1'b1;
        crc_nxt  = crc8_step(crc_r, cur_byte);
      end
    end
  end

  always_comb begin
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      motor_r     <= '0;
      byte_r      <= BYTE_ID;
      crc_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      motor_r     <= motor_nxt;
      byte_r      <= byte_nxt;
      crc_r       <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= q_data;
    end
    if (step) begin
      tx_byte_r      <= cur_byte;
      motor_number_r <= {1'b0, motor_r} + 3'd1;
      last_frame_r   <= is_last_frame;
      last_cmd_r     <= is_last_cmd;
    end
  end

  assign out_valid       = out_valid_r;
  assign tx_byte         = tx_byte_r;
  assign motor_number    = motor_number_r;
  assign last_of_frame   = last_frame_r;
  assign last_of_command = last_cmd_r;

endmodule

// ===== test/tb.sv =====
// self-checking bench for mecanum_wheel_packet_framer: directed corners, then random traffic
// checks every output byte against an inline kinematics, clamp and crc-8 predictor
// depends on mwpf_pkg and the framer rtl
`timescale 1ns / 100ps

module tb import mwpf_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 107;
  localparam longint MAX_RPM = 330;

  typedef struct {
    logic [7:0] tx;
    logic [2:0] motor;
    logic       lof;
    logic       loc;
  } frame_beat_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [17:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_vel_x = '0;
  logic signed [15:0] in_vel_y = '0;
  logic signed [15:0] in_yaw_rate = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_tx_byte;
  logic [2:0]         out_motor_number;
  logic               out_last_of_frame;
  logic               out_last_of_command;

  // shadow of the block's registers
  logic [17:0] arm_sh;
  logic [15:0] gain_sh;
  logic [8:0]  limit_sh;
  logic [3:0]  reverse_sh;

  frame_beat_t expected_beats[$];
  int          mismatch_count = 0;
  int          in_idle_pct = 0;
  int          out_stall_pct = 0;
  int          quiet_cycles = 0;

  mecanum_wheel_packet_framer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_vel_x           (in_vel_x),
    .in_vel_y           (in_vel_y),
    .in_yaw_rate        (in_yaw_rate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_byte        (out_tx_byte),
    .out_motor_number   (out_motor_number),
    .out_last_of_frame  (out_last_of_frame),
    .out_last_of_command(out_last_of_command)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // bitwise lsb-first crc, poly 0x8c, init 0
  function automatic logic [7:0] frame_crc(input logic [7:0] bytes[10]);
    logic [7:0] crc;
    logic [7:0] d;
    logic       mix;
    crc = 8'h00;
    for (int i = 0; i < 9; i++) begin
      d = bytes[i];
      for (int k = 0; k < 8; k++) begin
        mix = crc[0] ^ d[0];
        crc = crc >> 1;
        if (mix) crc = crc ^ 8'h8C;
        d = d >> 1;
      end
    end
    return crc;
  endfunction

  function automatic void predict_motor_frames(input logic signed [15:0] vx,
                                               input logic signed [15:0] vy,
                                               input logic signed [15:0] wz);
    longint      rot;
    longint      rpm;
    longint      lim;
    longint      wheel[4];
    logic [15:0] raw;
    logic [7:0]  bytes[10];
    frame_beat_t b;
    rot = (longint'(arm_sh) * longint'(wz)) >>> 16;
    wheel[0] = longint'(vx) - longint'(vy) - rot;
    wheel[1] = longint'(vx) + longint'(vy) + rot;
    wheel[2] = longint'(vx) + longint'(vy) - rot;
    wheel[3] = longint'(vx) - longint'(vy) + rot;
    lim = (longint'(limit_sh) > MAX_RPM) ? MAX_RPM : longint'(limit_sh);
    for (int m = 0; m < 4; m++) begin
      // signed division truncates toward zero
      rpm = (wheel[m] * longint'(gain_sh)) / 65536;
      if (rpm > lim) rpm = lim;
      if (rpm < -lim) rpm = -lim;
      if (reverse_sh[m]) rpm = -rpm;
      raw = rpm[15:0];
      bytes[0] = 8'(m + 1);
      bytes[1] = CMD_BYTE;
      bytes[2] = raw[15:8];
      bytes[3] = raw[7:0];
      bytes[4] = 8'h00;
      bytes[5] = 8'h00;
      bytes[6] = ACCEL_BYTE;
      bytes[7] = 8'h00;
      bytes[8] = 8'h00;
      bytes[9] = frame_crc(bytes);
      for (int i = 0; i < 10; i++) begin
        b.tx = bytes[i];
        b.motor = 3'(m + 1);
        b.lof = (i == 9);
        b.loc = (i == 9) && (m == 3);
        expected_beats.push_back(b);
      end
    end
  endfunction

  // output side: check each beat and pick the next ready level
  always @(posedge clk) begin
    frame_beat_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: byte %02h motor %0d lof %0b loc %0b", out_tx_byte,
                   out_motor_number, out_last_of_frame, out_last_of_command);
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_tx_byte !== exp_b.tx || out_motor_number !== exp_b.motor ||
            out_last_of_frame !== exp_b.lof || out_last_of_command !== exp_b.loc) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("beat mismatch: byte %02h/%02h motor %0d/%0d lof %0b/%0b loc %0b/%0b",
                     exp_b.tx, out_tx_byte, exp_b.motor, out_motor_number, exp_b.lof,
                     out_last_of_frame, exp_b.loc, out_last_of_command);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[mecanum_wheel_packet_framer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid is left high after a beat; the next call either reloads it or drops it
  task automatic send_command(input logic signed [15:0] vx, input logic signed [15:0] vy,
                              input logic signed [15:0] wz);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vel_x <= vx;
    in_vel_y <= vy;
    in_yaw_rate <= wz;
    do @(posedge clk); while (!in_ready);
    predict_motor_frames(vx, vy, wz);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ARM:     arm_sh = val[17:0];
      REG_GAIN:    gain_sh = val[15:0];
      REG_LIMIT:   limit_sh = val[8:0];
      REG_REVERSE: reverse_sh = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_config(input logic [17:0] arm, input logic [17:0] gain,
                             input logic [17:0] lim, input logic [17:0] rev);
    drain_results();
    write_reg(REG_ARM, arm);
    write_reg(REG_GAIN, gain);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_REVERSE, rev);
  endtask

  function automatic logic signed [15:0] pick_speed();
    int kind;
    kind = $urandom_range(99);
    if (kind < 40) return 16'($urandom_range(6000) - 3000);
    if (kind < 55) return 16'($urandom_range(200) - 100);
    if (kind < 90) return 16'($urandom);
    case ($urandom_range(4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_command(16'sd0, 16'sd0, 16'sd0);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_command(16'sh8000, 16'sh8000, 16'sh8000);
    send_command(16'sh7FFF, 16'sh8000, 16'sd0);
    send_command(16'sd100, -16'sd200, 16'sd300);
    send_command(-16'sd1, 16'sd1, -16'sd1);
  endtask

  task automatic test_register_corners();
    load_config(18'h3FFFF, 18'h0FFFF, 18'd330, 18'd0);
    send_command(16'sd1, 16'sd0, 16'sd0);
    send_command(16'sd0, 16'sd0, 16'sh7FFF);
    send_command(16'sh8000, 16'sh7FFF, 16'sh8000);
    // limit above the motor maximum, every motor reversed
    load_config(18'd0, 18'h0FFFF, 18'd511, 18'hF);
    send_command(16'sh7FFF, 16'sd0, 16'sd0);
    send_command(16'sh8000, 16'sd0, 16'sd0);
    // zero limit forces every rpm to zero
    drain_results();
    write_reg(REG_LIMIT, 18'd0);
    send_command(16'sd12345, -16'sd2345, 16'sd777);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    // value bits above the gain, limit and reverse register widths must be dropped
    load_config(18'h2C2A1, 18'h30010, 18'h3FF00, 18'h3FFF5);
    send_command(16'sd3000, -16'sd1500, 16'sd2000);
    send_command(-16'sd3000, 16'sd1500, -16'sd2000);
    load_config(18'd1, 18'd0, 18'd330, 18'hA);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
  endtask

  task automatic test_pause_until_drained();
    load_config(18'd49807, 18'd7823, 18'd300, 18'd6);
    in_idle_pct = 0;
    out_stall_pct = 30;
    for (int i = 0; i < 5; i++) send_command(pick_speed(), pick_speed(), pick_speed());
    drain_results();
    for (int i = 0; i < 5; i++) send_command(pick_speed(), pick_speed(), pick_speed());
  endtask

  task automatic test_random_traffic();
    int idle_of[4] = '{0, 56, 0, 14};
    int stall_of[4] = '{0, 0, 56, 14};
    for (int ph = 0; ph < 4; ph++) begin
      case ($urandom_range(3))
        0: load_config(18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
        1: load_config(18'h3FFFF, 18'h0FFFF, 18'd330, 18'hF);
        default: load_config(18'($urandom_range(131071)), 18'($urandom_range(16000)),
                             18'($urandom_range(511)), 18'($urandom_range(15)));
      endcase
      in_idle_pct = idle_of[ph];
      out_stall_pct = stall_of[ph];
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        send_command(pick_speed(), pick_speed(), pick_speed());
    end
  endtask

  initial begin
    arm_sh = 18'd49807;
    gain_sh = 16'd7823;
    limit_sh = 9'd30;
    reverse_sh = 4'd5;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_corners();
    test_pause_until_drained();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("[mecanum_wheel_packet_framer] OK");
    end else begin
      $display("[mecanum_wheel_packet_framer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mwpf_pkg.sv
rtl/mwpf_front.sv
rtl/mwpf_queue.sv
rtl/mwpf_back.sv
rtl/mecanum_wheel_packet_framer.sv
test/tb.sv
